// ===== sv/lrk_pkg.sv =====
package lrk_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DT_W      = 31;
  localparam int unsigned ROWS_W    = 7;
  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned MB_W      = DATA_W + 1;
  localparam int unsigned PROD_W    = DATA_W + MB_W;
  localparam int unsigned SH_W      = PROD_W - FRAC_BITS;
  localparam int unsigned WIDE_W    = 43;
  localparam int unsigned ACC_W     = 42;
  localparam int unsigned DIVM_W    = 40;
  localparam int unsigned DIVM_HALF = 20;
  localparam int unsigned RECIP_W   = 42;
  localparam int unsigned RECIP_HALF = 21;
  localparam int unsigned RECIP_SH  = 43;
  localparam int unsigned DPROD_W   = DIVM_W + RECIP_W;
  localparam int unsigned DIV_CYC   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // ceil(2^43 / 3)
  localparam logic [RECIP_W-1:0] RECIP_3 = 42'd2932031007403;

  localparam logic signed [DATA_W-1:0] SIGMA_RST = 32'sd167772160;
  localparam logic signed [DATA_W-1:0] BETA_RST  = 32'sd44739243;
  localparam logic signed [DATA_W-1:0] RHO_RST   = 32'sd469762048;
  localparam logic [DT_W-1:0]          DT_RST    = 31'd167772;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd3;

  typedef enum logic [2:0] {
    OP_DX  = 3'd0,
    OP_DY  = 3'd1,
    OP_DXY = 3'd2,
    OP_DBZ = 3'd3,
    OP_TX  = 3'd4,
    OP_TY  = 3'd5,
    OP_TZ  = 3'd6,
    OP_NOP = 3'd7
  } op_e;

  typedef struct packed {
    logic       load_start;
    logic       step_init;
    op_e        op;
    logic [1:0] stage;
    logic       div_start;
    logic       x_update;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = -WIDE_W'(33'sh080000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== sv/lrk_in_if.sv =====
interface lrk_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lrk_pkg::DATA_W-1:0]      start_x;
  logic signed [lrk_pkg::DATA_W-1:0]      start_y;
  logic signed [lrk_pkg::DATA_W-1:0]      start_z;
  logic        [lrk_pkg::ROWS_W-1:0]      row_count;

  modport source (output valid, start_x, start_y, start_z, row_count, input ready);
  modport sink (input valid, start_x, start_y, start_z, row_count, output ready);
endinterface

// ===== sv/lrk_out_if.sv =====
interface lrk_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lrk_pkg::DATA_W-1:0] pos_x;
  logic signed [lrk_pkg::DATA_W-1:0] pos_y;
  logic signed [lrk_pkg::DATA_W-1:0] pos_z;
  logic                              last_row;

  modport source (output valid, pos_x, pos_y, pos_z, last_row, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, last_row, output ready);
endinterface

// ===== sv/lrk_div6.sv =====
module lrk_div6 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [lrk_pkg::ACC_W-1:0]    dividend_i,
  output logic signed [lrk_pkg::ACC_W-1:0]    quot_o,
  output logic                                done_o
);

  logic                                    busy_q;
  logic [2:0]                              cnt_q;
  logic                                    neg_q;
  logic [lrk_pkg::DIVM_W-1:0]              m_q;
  logic [lrk_pkg::DPROD_W-1:0]             acc_q, acc_d;
  logic [lrk_pkg::ACC_W-1:0]               mag;
  logic [lrk_pkg::DIVM_HALF-1:0]           m_part;
  logic [lrk_pkg::RECIP_HALF-1:0]          r_part;
  logic [lrk_pkg::DIVM_HALF+lrk_pkg::RECIP_HALF-1:0] pp;
  logic [lrk_pkg::DPROD_W-1:0]             pp_ext;
  logic [lrk_pkg::ACC_W-1:0]               q_mag;

  // magnitude halved, then times the reciprocal of three
  assign mag = dividend_i[lrk_pkg::ACC_W-1] ? lrk_pkg::ACC_W'(-dividend_i)
                                            : lrk_pkg::ACC_W'(dividend_i);

  always_comb begin
    m_part = cnt_q[0] ? m_q[lrk_pkg::DIVM_W-1:lrk_pkg::DIVM_HALF]
                      : m_q[lrk_pkg::DIVM_HALF-1:0];
    r_part = cnt_q[1] ? lrk_pkg::RECIP_3[lrk_pkg::RECIP_W-1:lrk_pkg::RECIP_HALF]
                      : lrk_pkg::RECIP_3[lrk_pkg::RECIP_HALF-1:0];
    pp = (lrk_pkg::DIVM_HALF + lrk_pkg::RECIP_HALF)'(m_part) *
         (lrk_pkg::DIVM_HALF + lrk_pkg::RECIP_HALF)'(r_part);
    unique case (cnt_q[1:0])
      2'd0: pp_ext = lrk_pkg::DPROD_W'(pp);
      2'd1: pp_ext = lrk_pkg::DPROD_W'(pp) << lrk_pkg::DIVM_HALF;
      2'd2: pp_ext = lrk_pkg::DPROD_W'(pp) << lrk_pkg::RECIP_HALF;
      2'd3: pp_ext = lrk_pkg::DPROD_W'(pp) << (lrk_pkg::DIVM_HALF + lrk_pkg::RECIP_HALF);
    endcase
    acc_d = acc_q + pp_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == 3'(lrk_pkg::DIV_CYC)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[lrk_pkg::ACC_W-1];
      m_q   <= mag[lrk_pkg::DIVM_W:1];
      acc_q <= '0;
    end else if (busy_q && cnt_q != 3'(lrk_pkg::DIV_CYC)) begin
      acc_q <= acc_d;
    end
  end

  assign q_mag  = lrk_pkg::ACC_W'(acc_q[lrk_pkg::DPROD_W-1:lrk_pkg::RECIP_SH]);
  assign quot_o = neg_q ? -$signed(q_mag) : $signed(q_mag);
  assign done_o = busy_q && (cnt_q == 3'(lrk_pkg::DIV_CYC));

endmodule

// ===== sv/lrk_dp.sv =====
module lrk_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrk_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lrk_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic signed [lrk_pkg::DATA_W-1:0]    start_x_i,
  input  logic signed [lrk_pkg::DATA_W-1:0]    start_y_i,
  input  logic signed [lrk_pkg::DATA_W-1:0]    start_z_i,
  input  lrk_pkg::cmd_t                        cmd_i,
  output lrk_pkg::status_t                     status_o,
  output logic signed [lrk_pkg::DATA_W-1:0]    pos_x_o,
  output logic signed [lrk_pkg::DATA_W-1:0]    pos_y_o,
  output logic signed [lrk_pkg::DATA_W-1:0]    pos_z_o
);

  logic signed [lrk_pkg::DATA_W-1:0]  sigma_q, beta_q, rho_q;
  logic        [lrk_pkg::DT_W-1:0]    dt_q;

  logic signed [lrk_pkg::DATA_W-1:0]  x_q [3];
  logic signed [lrk_pkg::DATA_W-1:0]  p_q [3];
  logic signed [lrk_pkg::DATA_W-1:0]  k_q [3];
  logic signed [lrk_pkg::ACC_W-1:0]   acc_q [3];
  logic signed [lrk_pkg::SH_W-1:0]    tmp_q;
  logic signed [lrk_pkg::PROD_W-1:0]  prod_q, prod_d;
  lrk_pkg::op_e                       wb_op_q;
  logic [1:0]                         wb_stage_q;

  logic signed [lrk_pkg::DATA_W-1:0]  ma;
  logic signed [lrk_pkg::MB_W-1:0]    mb;
  logic signed [lrk_pkg::WIDE_W-1:0]  s24, s25, half;
  logic signed [lrk_pkg::ACC_W-1:0]   t_acc;
  logic [1:0]                         lane;
  logic signed [lrk_pkg::ACC_W-1:0]   quot [3];
  logic [2:0]                         done;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= lrk_pkg::SIGMA_RST;
      beta_q  <= lrk_pkg::BETA_RST;
      rho_q   <= lrk_pkg::RHO_RST;
      dt_q    <= lrk_pkg::DT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrk_pkg::REG_SIGMA: sigma_q <= $signed(cfg_data_i);
        lrk_pkg::REG_BETA:  beta_q  <= $signed(cfg_data_i);
        lrk_pkg::REG_RHO:   rho_q   <= $signed(cfg_data_i);
        lrk_pkg::REG_DT:    dt_q    <= cfg_data_i[lrk_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      lrk_pkg::OP_DX: begin
        ma = sigma_q;
        mb = {p_q[1][lrk_pkg::DATA_W-1], p_q[1]} - {p_q[0][lrk_pkg::DATA_W-1], p_q[0]};
      end
      lrk_pkg::OP_DY: begin
        ma = p_q[0];
        mb = {rho_q[lrk_pkg::DATA_W-1], rho_q} - {p_q[2][lrk_pkg::DATA_W-1], p_q[2]};
      end
      lrk_pkg::OP_DXY: begin
        ma = p_q[0];
        mb = lrk_pkg::MB_W'(p_q[1]);
      end
      lrk_pkg::OP_DBZ: begin
        ma = beta_q;
        mb = lrk_pkg::MB_W'(p_q[2]);
      end
      lrk_pkg::OP_TX: begin
        ma = k_q[0];
        mb = $signed({2'b00, dt_q});
      end
      lrk_pkg::OP_TY: begin
        ma = k_q[1];
        mb = $signed({2'b00, dt_q});
      end
      lrk_pkg::OP_TZ: begin
        ma = k_q[2];
        mb = $signed({2'b00, dt_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d = lrk_pkg::PROD_W'(ma) * lrk_pkg::PROD_W'(mb);

  // scaled product views, floor rounding
  assign s24  = lrk_pkg::WIDE_W'(prod_q >>> lrk_pkg::FRAC_BITS);
  assign s25  = lrk_pkg::WIDE_W'(prod_q >>> (lrk_pkg::FRAC_BITS + 1));
  assign half = (wb_stage_q == 2'd0 || wb_stage_q == 2'd1) ? s25 : s24;
  assign t_acc = (wb_stage_q == 2'd1 || wb_stage_q == 2'd2) ?
                 (lrk_pkg::ACC_W'(s24) <<< 1) : lrk_pkg::ACC_W'(s24);

  always_comb begin
    unique case (wb_op_q)
      lrk_pkg::OP_TY: lane = 2'd1;
      lrk_pkg::OP_TZ: lane = 2'd2;
      default:        lane = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_op_q    <= lrk_pkg::OP_NOP;
      wb_stage_q <= '0;
    end else begin
      wb_op_q    <= cmd_i.op;
      wb_stage_q <= cmd_i.stage;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_start) begin
      x_q[0] <= start_x_i;
      x_q[1] <= start_y_i;
      x_q[2] <= start_z_i;
    end else if (cmd_i.x_update) begin
      for (int i = 0; i < 3; i++) begin
        x_q[i] <= lrk_pkg::sat32(lrk_pkg::WIDE_W'(x_q[i]) + lrk_pkg::WIDE_W'(quot[i]));
      end
    end
    if (cmd_i.step_init) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i]   <= x_q[i];
        acc_q[i] <= '0;
      end
    end else begin
      unique case (wb_op_q)
        lrk_pkg::OP_DX:  k_q[0] <= lrk_pkg::sat32(s24);
        lrk_pkg::OP_DY:  k_q[1] <= lrk_pkg::sat32(s24 - lrk_pkg::WIDE_W'(p_q[1]));
        lrk_pkg::OP_DXY: tmp_q  <= s24[lrk_pkg::SH_W-1:0];
        lrk_pkg::OP_DBZ: k_q[2] <= lrk_pkg::sat32(lrk_pkg::WIDE_W'(tmp_q) - s24);
        lrk_pkg::OP_TX, lrk_pkg::OP_TY, lrk_pkg::OP_TZ: begin
          p_q[lane]   <= lrk_pkg::sat32(lrk_pkg::WIDE_W'(x_q[lane]) + half);
          acc_q[lane] <= acc_q[lane] + t_acc;
        end
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    lrk_div6 u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (cmd_i.div_start),
      .dividend_i (acc_q[g]),
      .quot_o     (quot[g]),
      .done_o     (done[g])
    );
  end

  assign status_o.div_done = &done;
  assign pos_x_o = x_q[0];
  assign pos_y_o = x_q[1];
  assign pos_z_o = x_q[2];

endmodule

// ===== sv/lrk_ctrl.sv =====
module lrk_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lrk_pkg::ROWS_W-1:0]     row_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           last_row_o,
  output lrk_pkg::cmd_t                  cmd_o,
  input  lrk_pkg::status_t               status_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EMIT  = 5'b00010,
    S_STEP  = 5'b00100,
    S_DIVGO = 5'b01000,
    S_DIVW  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [lrk_pkg::ROWS_W-1:0]    rows_q, rows_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic [lrk_pkg::ROWS_W-1:0]    n_sat;

  always_comb begin
    if (row_count_i == '0) begin
      n_sat = lrk_pkg::ROWS_W'(1);
    end else if (row_count_i > lrk_pkg::ROWS_W'(lrk_pkg::MAX_ROWS)) begin
      n_sat = lrk_pkg::ROWS_W'(lrk_pkg::MAX_ROWS);
    end else begin
      n_sat = row_count_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign last_row_o  = (rows_q == lrk_pkg::ROWS_W'(1));

  always_comb begin
    state_d = state_q;
    rows_d  = rows_q;
    cnt_d   = cnt_q;
    cmd_o   = '{load_start: 1'b0, step_init: 1'b0, op: lrk_pkg::OP_NOP,
                stage: cnt_q[4:3], div_start: 1'b0, x_update: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_start = 1'b1;
          rows_d  = n_sat;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready_i) begin
          rows_d = rows_q - lrk_pkg::ROWS_W'(1);
          if (last_row_o) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.step_init = 1'b1;
            cnt_d   = '0;
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        cmd_o.op = lrk_pkg::op_e'(cnt_q[2:0]);
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (status_i.div_done) begin
          cmd_o.x_update = 1'b1;
          state_d = S_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rows_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      rows_q  <= rows_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("request accepted but start point not presented");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_row_o |=> in_ready_o)
    else $error("not idle after last row");
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !status_i.div_done)
    else $error("divider done too early");
  a_rows_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rows_q != '0)
    else $error("row presented with no rows left");
`endif

endmodule

// ===== sv/lorenz_rk4_integrator.sv =====
// lorenz trajectory generator, classical rk4, signed q8.24
// in_i: one request = start point and row count (0 taken as 1, above 64 as 64)
// out_o: row_count rows per request, the start point first, then one rk4 step
//   per row; last_row marks the final row of the request
// cfg: write cfg_data_i to register cfg_idx_i when cfg_we_i is high
//   (0 sigma, 1 beta, 2 rho, 3 step size); other indexes are ignored
// one request at a time: in_i.ready is high only while no request is open
// latency: the start point appears the cycle after acceptance
// each further row is computed after the previous one is taken: first on
//   the single shared 32x33 multiplier (four derivative stages, four products
//   and three step products each, one writeback slot), then in the three
//   divide-by-six units, one 20x21 partial product of the reciprocal per cycle
// a row stays on out_o until taken; computation of the next row waits
// reset restores the default coefficients and leaves the block idle
module lorenz_rk4_integrator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lrk_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lrk_pkg::DATA_W-1:0]         cfg_data_i,
  lrk_in_if.sink                             in_i,
  lrk_out_if.source                          out_o
);

  lrk_pkg::cmd_t    cmd;
  lrk_pkg::status_t status;

  lrk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .row_count_i (in_i.row_count),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .last_row_o  (out_o.last_row),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lrk_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_x_i  (in_i.start_x),
    .start_y_i  (in_i.start_y),
    .start_z_i  (in_i.start_z),
    .cmd_i      (cmd),
    .status_o   (status),
    .pos_x_o    (out_o.pos_x),
    .pos_y_o    (out_o.pos_y),
    .pos_z_o    (out_o.pos_z)
  );

endmodule
